// ===== src/hnf_pkg.sv =====
// ----------------------------------------------------------------------------
// hnf_pkg
// Shared constants, codes, types and helper functions of the hex number
// formatter.
// ----------------------------------------------------------------------------
package hnf_pkg;

  // Configuration of the datapath.
  localparam int VALUE_BITS = 64;
  localparam int MAX_WIDTH  = 64;

  // Fixed field widths of the channels.
  localparam int CMD_W  = 2;
  localparam int VAL_W  = 64;
  localparam int FW_W   = 7;
  localparam int MD_W   = 6;
  localparam int CHAR_W = 8;

  // Derived sizes.
  localparam int NDIG_MAX = (VALUE_BITS + 3) / 4;
  localparam int DIG_W    = NDIG_MAX * 4;
  localparam int NDIG_W   = $clog2(NDIG_MAX + 1);
  localparam int NIB_W    = (NDIG_MAX > 1) ? $clog2(NDIG_MAX) : 1;
  localparam int CNT_W    = $clog2(MAX_WIDTH + 1);

  // Queue between the front and the back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_LOWER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UPPER = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PTR   = 2'd2;

  // Characters.
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_X_UP  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_A_LO  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_A_UP  = 8'h41;

  // One classified item: how many characters each segment of the text has.
  typedef struct packed {
    logic [DIG_W-1:0]  value;
    logic              upper;
    logic              pfx;
    logic [CNT_W-1:0]  lspc;
    logic [CNT_W-1:0]  zcnt;
    logic [NDIG_W-1:0] ndig;
    logic [CNT_W-1:0]  rspc;
  } desc_t;

  // Segments of the text in output order.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LSPC,
    BK_PFX0,
    BK_PFX1,
    BK_ZERO,
    BK_DIG,
    BK_RSPC
  } back_state_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib, input logic upper);
    logic [CHAR_W-1:0] ch;
    if (nib < 4'd10) begin
      ch = CH_ZERO + CHAR_W'(nib);
    end else if (upper) begin
      ch = CH_A_UP + CHAR_W'(nib - 4'd10);
    end else begin
      ch = CH_A_LO + CHAR_W'(nib - 4'd10);
    end
    return ch;
  endfunction

endpackage

// ===== src/hnf_if.sv =====
// ----------------------------------------------------------------------------
// hnf_if
// Valid/ready channels of the hex number formatter: formatting requests in,
// characters out.
// ----------------------------------------------------------------------------
interface hnf_in_if;
  import hnf_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [VAL_W-1:0]  value;
  logic              alt_form;
  logic              left_justify;
  logic              zero_pad;
  logic [FW_W-1:0]   field_width;
  logic [MD_W-1:0]   min_digits;

  modport source (
    output valid, cmd, value, alt_form, left_justify, zero_pad, field_width, min_digits,
    input  ready
  );
  modport sink (
    input  valid, cmd, value, alt_form, left_justify, zero_pad, field_width, min_digits,
    output ready
  );
endinterface

interface hnf_out_if;
  import hnf_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              last;

  modport source (
    output valid, out_char, last,
    input  ready
  );
  modport sink (
    input  valid, out_char, last,
    output ready
  );
endinterface

// ===== src/hnf_front.sv =====
// ----------------------------------------------------------------------------
// hnf_front
// Accepts a request, holds it until the queue takes it and classifies it into segment
// lengths (spaces, prefix, zeros, digits, spaces) for the back end.
// ----------------------------------------------------------------------------
module hnf_front (
  input  logic          clk,
  input  logic          rst_n,
  hnf_in_if.sink        in_ch,
  output logic          push_valid,
  input  logic          push_ready,
  output hnf_pkg::desc_t push_data
);
  import hnf_pkg::*;

  logic              hold_valid_r;
  logic              hold_valid_nxt;
  logic [CMD_W-1:0]  cmd_r;
  logic [DIG_W-1:0]  value_r;
  logic              alt_r;
  logic              left_r;
  logic              zpad_r;
  logic [FW_W-1:0]   fw_r;
  logic [MD_W-1:0]   md_r;

  logic              take;
  logic [NDIG_W-1:0] ndig;
  logic [FW_W-1:0]   fw_sat;
  logic [FW_W-1:0]   prec;
  logic [FW_W-1:0]   ndig_ext;
  logic [FW_W-1:0]   nd;
  logic [FW_W-1:0]   lead;
  logic [FW_W-1:0]   body;
  logic [FW_W-1:0]   pad;
  logic              is_ptr;
  logic              plen;

  assign in_ch.ready = !hold_valid_r || push_ready;
  assign take        = in_ch.valid && in_ch.ready;
  assign push_valid  = hold_valid_r;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (take) begin
      hold_valid_nxt = 1'b1;
    end else if (push_ready) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r   <= in_ch.cmd;
      value_r <= DIG_W'(in_ch.value[VALUE_BITS-1:0]);
      alt_r   <= in_ch.alt_form;
      left_r  <= in_ch.left_justify;
      zpad_r  <= in_ch.zero_pad;
      fw_r    <= in_ch.field_width;
      md_r    <= in_ch.min_digits;
    end
  end

  // Number of significant hex digits, at least one.
  always_comb begin
    ndig = NDIG_W'(1);
    for (int i = 0; i < NDIG_MAX; i++) begin
      if (value_r[i*4 +: 4] != 4'd0) begin
        ndig = NDIG_W'(i + 1);
      end
    end
  end

  always_comb begin
    is_ptr   = !(cmd_r == CMD_LOWER || cmd_r == CMD_UPPER);
    plen     = alt_r && (value_r != '0);
    fw_sat   = (fw_r > FW_W'(MAX_WIDTH)) ? FW_W'(MAX_WIDTH) : fw_r;
    prec     = (FW_W'(md_r) > FW_W'(MAX_WIDTH - 2)) ? FW_W'(MAX_WIDTH - 2) : FW_W'(md_r);
    ndig_ext = FW_W'(ndig);
    nd       = (prec > ndig_ext) ? prec : ndig_ext;
    lead     = nd - ndig_ext;
    // The prefix is two characters wide.
    body     = nd + (plen ? FW_W'(2) : FW_W'(0));
    pad      = (fw_sat > body) ? fw_sat - body : '0;
  end

  always_comb begin
    push_data.value = value_r;
    push_data.ndig  = ndig;
    if (is_ptr) begin
      push_data.upper = 1'b0;
      push_data.pfx   = 1'b1;
      push_data.lspc  = '0;
      push_data.zcnt  = '0;
      push_data.rspc  = '0;
    end else begin
      push_data.upper = (cmd_r == CMD_UPPER);
      push_data.pfx   = plen;
      if (left_r) begin
        push_data.lspc = '0;
        push_data.zcnt = CNT_W'(lead);
        push_data.rspc = CNT_W'(pad);
      end else if (zpad_r && md_r == '0) begin
        // Zero padding sits between the prefix and the digits.
        push_data.lspc = '0;
        push_data.zcnt = CNT_W'(pad);
        push_data.rspc = '0;
      end else begin
        push_data.lspc = CNT_W'(pad);
        push_data.zcnt = CNT_W'(lead);
        push_data.rspc = '0;
      end
    end
  end

endmodule

// ===== src/hnf_queue.sv =====
// ----------------------------------------------------------------------------
// hnf_queue
// Small first-in first-out queue of classified items between the front and
// the back.
// ----------------------------------------------------------------------------
module hnf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  hnf_pkg::desc_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output hnf_pkg::desc_t pop_data
);
  import hnf_pkg::*;

  desc_t             entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/hnf_back.sv =====
// ----------------------------------------------------------------------------
// hnf_back
// Walks the segments of one classified item and sends one character per
// cycle through an output register while the receiver is ready.
// ----------------------------------------------------------------------------
module hnf_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  hnf_pkg::desc_t pop_data,
  hnf_out_if.source      out_ch
);
  import hnf_pkg::*;

  back_state_t       state_r;
  back_state_t       state_nxt;
  back_state_t       succ;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  desc_t             desc_r;
  desc_t             desc_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r;
  logic [CHAR_W-1:0] out_char_nxt;
  logic              out_last_r;
  logic              out_last_nxt;

  logic              adv;
  logic              emit;
  logic [CHAR_W-1:0] ch;
  logic [CNT_W-1:0]  dig_pos;
  logic [NIB_W-1:0]  nib_idx;

  // First nonempty segment at or after the given one.
  function automatic back_state_t first_phase(input back_state_t from, input desc_t d);
    back_state_t r;
    if (from == BK_LSPC && d.lspc != '0) begin
      r = BK_LSPC;
    end else if ((from == BK_LSPC || from == BK_PFX0) && d.pfx) begin
      r = BK_PFX0;
    end else if ((from == BK_LSPC || from == BK_PFX0 || from == BK_ZERO) && d.zcnt != '0) begin
      r = BK_ZERO;
    end else if (from == BK_LSPC || from == BK_PFX0 || from == BK_ZERO || from == BK_DIG) begin
      r = BK_DIG;
    end else if (from == BK_RSPC && d.rspc != '0) begin
      r = BK_RSPC;
    end else begin
      r = BK_IDLE;
    end
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] phase_count(input back_state_t ph, input desc_t d);
    logic [CNT_W-1:0] c;
    case (ph)
      BK_LSPC: c = d.lspc;
      BK_ZERO: c = d.zcnt;
      BK_DIG:  c = CNT_W'(d.ndig);
      BK_RSPC: c = d.rspc;
      default: c = CNT_W'(1);
    endcase
    return c;
  endfunction

  assign adv       = !out_valid_r || out_ch.ready;
  assign pop_ready = (state_r == BK_IDLE);

  // Segment that follows the current one once its count runs out.
  always_comb begin
    case (state_r)
      BK_LSPC: succ = first_phase(BK_PFX0, desc_r);
      BK_PFX0: succ = BK_PFX1;
      BK_PFX1: succ = first_phase(BK_ZERO, desc_r);
      BK_ZERO: succ = BK_DIG;
      BK_DIG:  succ = first_phase(BK_RSPC, desc_r);
      default: succ = BK_IDLE;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    desc_nxt  = desc_r;
    case (state_r)
      BK_IDLE: begin
        if (pop_valid) begin
          desc_nxt  = pop_data;
          state_nxt = first_phase(BK_LSPC, pop_data);
          cnt_nxt   = phase_count(first_phase(BK_LSPC, pop_data), pop_data);
        end
      end
      default: begin
        if (adv) begin
          if (cnt_r > CNT_W'(1)) begin
            cnt_nxt = cnt_r - 1'b1;
          end else begin
            state_nxt = succ;
            cnt_nxt   = phase_count(succ, desc_r);
          end
        end
      end
    endcase
  end

  // Character of the current position.
  always_comb begin
    dig_pos = cnt_r - 1'b1;
    nib_idx = dig_pos[NIB_W-1:0];
    emit    = (state_r != BK_IDLE);
    case (state_r)
      BK_LSPC: ch = CH_SPACE;
      BK_PFX0: ch = CH_ZERO;
      BK_PFX1: ch = desc_r.upper ? CH_X_UP : CH_X_LO;
      BK_ZERO: ch = CH_ZERO;
      BK_DIG:  ch = hex_char(desc_r.value[nib_idx*4 +: 4], desc_r.upper);
      BK_RSPC: ch = CH_SPACE;
      default: ch = CH_SPACE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (adv) begin
      out_valid_nxt = emit;
      if (emit) begin
        out_char_nxt = ch;
        out_last_nxt = (cnt_r == CNT_W'(1)) && (succ == BK_IDLE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    desc_r     <= desc_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_char = out_char_r;
  assign out_ch.last     = out_last_r;

endmodule

// ===== src/hex_number_formatter.sv =====
// ----------------------------------------------------------------------------
// hex_number_formatter
// Formats a number as printf-style hexadecimal text, one character per item.
// A request with N characters (1 to 64) occupies the character sequencer until
// its last character enters the output register and the sequencer returns to idle;
// one character leaves per cycle while the receiver is ready.
// Reset: synchronous, active low; clears the queue, sequencer and output valid.
// ----------------------------------------------------------------------------
module hex_number_formatter (
  input  logic      clk,
  input  logic      rst_n,
  hnf_in_if.sink    in_ch,
  hnf_out_if.source out_ch
);
  import hnf_pkg::*;

  logic  push_valid;
  logic  push_ready;
  desc_t push_data;
  logic  pop_valid;
  logic  pop_ready;
  desc_t pop_data;

  hnf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  hnf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  hnf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the hex number formatter. Requests go in over a
// valid/ready channel with random gaps and come back as ASCII characters.
// Each accepted request is turned into its expected text here, and each
// accepted character is compared in order, the last flag included.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import hnf_pkg::*;

  // The selector value that has no command of its own; it formats as a pointer.
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  localparam int RESET_CYCLES  = 11;
  localparam int MAX_GAP       = 16;
  localparam int LONG_HOLD     = 500;
  localparam int WATCHDOG_IDLE = 3000;
  localparam int RANDOM_ITEMS  = 420;
  localparam int PHASE_ITEMS   = 60;
  localparam int TAIL_CYCLES   = 20;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [VAL_W-1:0] value;
    logic             alt_form;
    logic             left_just;
    logic             zero_pad;
    logic [FW_W-1:0]  field_width;
    logic [MD_W-1:0]  min_digits;
  } fmt_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } char_exp_t;

  class char_scoreboard;
    char_exp_t         pending[$];
    logic [CHAR_W-1:0] text[$];
    int                mismatches;

    function new();
      mismatches = 0;
    endfunction

    function void put_run(input logic [CHAR_W-1:0] ch, input int count);
      for (int k = 0; k < count; k++) text.push_back(ch);
    endfunction

    function void put_hex(input logic [VAL_W-1:0] v, input int ndig, input bit upper);
      string digits_lo;
      string digits_up;
      int    nib;
      digits_lo = "0123456789abcdef";
      digits_up = "0123456789ABCDEF";
      for (int k = ndig; k > 0; k--) begin
        nib = int'((v >> ((k - 1) * 4)) & 64'hF);
        text.push_back(upper ? digits_up[nib] : digits_lo[nib]);
      end
    endfunction

    // Builds the full text of one request and queues it character by character.
    function void note_request(input fmt_req_t r);
      logic [VAL_W-1:0]  rest;
      logic [CHAR_W-1:0] xch;
      bit                upper;
      int                ndig, wid, prec, plen, nd, lead, pad;
      char_exp_t         e;
      text.delete();
      ndig = 1;
      rest = r.value >> 4;
      while (rest != 0) begin
        ndig++;
        rest = rest >> 4;
      end
      if (r.cmd == CMD_PTR || r.cmd == CMD_SPARE) begin
        text.push_back(CH_ZERO);
        text.push_back(CH_X_LO);
        put_hex(r.value, ndig, 1'b0);
      end else begin
        upper = (r.cmd == CMD_UPPER);
        xch   = upper ? CH_X_UP : CH_X_LO;
        wid   = (int'(r.field_width) > MAX_WIDTH) ? MAX_WIDTH : int'(r.field_width);
        prec  = (int'(r.min_digits) > MAX_WIDTH - 2) ? MAX_WIDTH - 2 : int'(r.min_digits);
        plen  = (r.alt_form && r.value != 0) ? 2 : 0;
        nd    = (prec > ndig) ? prec : ndig;
        lead  = nd - ndig;
        pad   = (wid > plen + nd) ? wid - plen - nd : 0;
        if (r.left_just) begin
          if (plen != 0) begin
            text.push_back(CH_ZERO);
            text.push_back(xch);
          end
          put_run(CH_ZERO, lead);
          put_hex(r.value, ndig, upper);
          put_run(CH_SPACE, pad);
        end else if (r.zero_pad && prec == 0) begin
          if (plen != 0) begin
            text.push_back(CH_ZERO);
            text.push_back(xch);
          end
          put_run(CH_ZERO, pad);
          put_hex(r.value, ndig, upper);
        end else begin
          put_run(CH_SPACE, pad);
          if (plen != 0) begin
            text.push_back(CH_ZERO);
            text.push_back(xch);
          end
          put_run(CH_ZERO, lead);
          put_hex(r.value, ndig, upper);
        end
      end
      while (text.size() > MAX_WIDTH) void'(text.pop_back());
      for (int k = 0; k < text.size(); k++) begin
        e.ch   = text[k];
        e.last = (k == text.size() - 1);
        pending.push_back(e);
      end
    endfunction

    function void check_char(input logic [CHAR_W-1:0] ch, input logic last);
      char_exp_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: character %h last %b arrived with nothing expected", $time, ch, last);
      end else begin
        e = pending.pop_front();
        if (e.ch !== ch || e.last !== last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: expected character %h last %b, got %h last %b",
                     $time, e.ch, e.last, ch, last);
        end
      end
    endfunction

    function bit clean();
      return mismatches == 0 && pending.size() == 0;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   in_quiet;
  bit   out_quiet;
  bit   hold_request;

  hnf_in_if  in_bus();
  hnf_out_if out_bus();

  hex_number_formatter DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  char_scoreboard sb = new();

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_gap(input bit quiet);
    return quiet ? 0 : int'($urandom_range(0, MAX_GAP));
  endfunction

  function automatic fmt_req_t make_req(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] v,
                                        input bit alt, input bit lj, input bit zp,
                                        input int fw, input int md);
    fmt_req_t r;
    r.cmd         = cmd;
    r.value       = v;
    r.alt_form    = alt;
    r.left_just   = lj;
    r.zero_pad    = zp;
    r.field_width = FW_W'(fw);
    r.min_digits  = MD_W'(md);
    return r;
  endfunction

  // Most requests stay short; a few reach the widest and most precise forms.
  function automatic fmt_req_t random_req();
    fmt_req_t r;
    int       sel, shift;
    sel = $urandom_range(0, 9);
    if (sel < 4) r.cmd = CMD_LOWER;
    else if (sel < 8) r.cmd = CMD_UPPER;
    else if (sel == 8) r.cmd = CMD_PTR;
    else r.cmd = CMD_SPARE;
    shift   = $urandom_range(0, 64);
    r.value = {$urandom, $urandom};
    r.value = (shift == 64) ? '0 : r.value >> shift;
    r.alt_form  = $urandom_range(0, 1);
    r.left_just = $urandom_range(0, 1);
    r.zero_pad  = $urandom_range(0, 1);
    sel = $urandom_range(0, 19);
    if (sel < 12) r.field_width = FW_W'($urandom_range(0, 24));
    else if (sel < 17) r.field_width = FW_W'($urandom_range(0, 64));
    else r.field_width = FW_W'($urandom_range(65, 127));
    sel = $urandom_range(0, 19);
    if (sel < 12) r.min_digits = '0;
    else if (sel < 17) r.min_digits = MD_W'($urandom_range(1, 20));
    else r.min_digits = MD_W'($urandom_range(21, 63));
    return r;
  endfunction

  task automatic send_request(input fmt_req_t r);
    int gap;
    gap = draw_gap(in_quiet);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.cmd          <= r.cmd;
    in_bus.value        <= r.value;
    in_bus.alt_form     <= r.alt_form;
    in_bus.left_justify <= r.left_just;
    in_bus.zero_pad     <= r.zero_pad;
    in_bus.field_width  <= r.field_width;
    in_bus.min_digits   <= r.min_digits;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    sb.note_request(r);
  endtask

  // Receiver: a fresh stall is drawn after every accepted character.
  initial begin
    int stall_left;
    stall_left    = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = LONG_HOLD;
        out_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) out_bus.ready <= 1'b1;
      end else if (out_bus.valid && out_bus.ready) begin
        stall_left = draw_gap(out_quiet);
        if (stall_left > 0) out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) sb.check_char(out_bus.out_char, out_bus.last);
  end

  initial begin
    int idle;
    idle = 0;
    @(posedge rst_n);
    while (idle < WATCHDOG_IDLE) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) idle = 0;
      else idle++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    rst_n               = 1'b0;
    in_quiet            = 1'b0;
    out_quiet           = 1'b0;
    hold_request        = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.cmd          = CMD_LOWER;
    in_bus.value        = '0;
    in_bus.alt_form     = 1'b0;
    in_bus.left_justify = 1'b0;
    in_bus.zero_pad     = 1'b0;
    in_bus.field_width  = '0;
    in_bus.min_digits   = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero has a single significant digit and, outside the pointer form, never takes the prefix.
    send_request(make_req(CMD_LOWER, 64'd0, 1, 0, 0, 0, 0));
    send_request(make_req(CMD_UPPER, 64'd0, 1, 0, 1, 6, 0));
    send_request(make_req(CMD_LOWER, 64'd1, 0, 0, 0, 1, 1));
    send_request(make_req(CMD_UPPER, '1, 1, 0, 0, 64, 0));
    send_request(make_req(CMD_LOWER, '1, 1, 0, 0, 5, 0));
    send_request(make_req(CMD_LOWER, 64'hABCD_EF01, 1, 1, 0, 40, 0));
    send_request(make_req(CMD_UPPER, 64'hABCD_EF01, 1, 1, 1, 40, 12));
    send_request(make_req(CMD_LOWER, 64'h5A, 1, 0, 1, 20, 0));
    send_request(make_req(CMD_LOWER, 64'h5A, 1, 0, 1, 20, 4));
    send_request(make_req(CMD_UPPER, 64'hFACE, 0, 0, 1, 127, 0));
    send_request(make_req(CMD_UPPER, 64'hFACE, 1, 0, 0, 100, 30));
    send_request(make_req(CMD_LOWER, 64'h8000_0000_0000_0000, 1, 0, 0, 0, 63));
    send_request(make_req(CMD_UPPER, 64'h7, 0, 1, 0, 127, 62));
    send_request(make_req(CMD_LOWER, 64'h123, 0, 0, 0, 64, 0));
    // Pointer form ignores every flag, the width and the precision.
    send_request(make_req(CMD_PTR, 64'hDEAD_BEEF, 1, 1, 1, 64, 62));
    send_request(make_req(CMD_PTR, 64'd0, 1, 0, 1, 127, 63));
    send_request(make_req(CMD_PTR, '1, 0, 0, 0, 0, 0));
    send_request(make_req(CMD_SPARE, 64'hC0FFEE, 1, 1, 0, 30, 10));
    send_request(make_req(CMD_SPARE, 64'h55AA_55AA_55AA_55AA, 0, 0, 1, 64, 0));

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % PHASE_ITEMS == 0) begin
        in_quiet  = ($urandom_range(0, 3) == 0);
        out_quiet = ($urandom_range(0, 3) == 0);
      end
      // Backpressure: the receiver stops for a long time while requests keep coming.
      if (k == 100 || k == 310) hold_request = 1'b1;
      send_request(random_req());
    end
    in_bus.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.clean()) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
